@@ design/lpmd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
   localparam int PHASE_W      = 2;

   localparam logic [PHASE_W-1:0] PHASE_HEADER  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_HALTED  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ID_BIG  = 2'd1;
   localparam logic [1:0] STATUS_LEN_BIG = 2'd2;
   localparam logic [1:0] STATUS_LINK    = 2'd3;

   localparam logic [15:0] LIMIT_RESET = 16'd2048;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       link_error;
   } item_type;

   typedef struct packed {
      logic [15:0] message_id;
      logic [15:0] message_length;
      logic [7:0]  payload_byte;
      logic        has_byte;
      logic        last;
      logic [1:0]  status;
   } result_type;

endpackage

@@ design/lpmd_in_stage.sv @@
// ----------------------------------------------------------------------------
// lpmd_in_stage
// Input register: holds one received beat until the parser consumes it.
// ----------------------------------------------------------------------------
module lpmd_in_stage
   import lpmd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ design/lpmd_parse.sv @@
// ----------------------------------------------------------------------------
// lpmd_parse
// Header/payload state, limit register and result decode for one beat.
// ----------------------------------------------------------------------------
module lpmd_parse
   import lpmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        step,
   input  item_type    item,
   output logic        res_valid,
   output result_type  result
);

   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [HDR_CNT_W-1:0] count_ff, count_in;
   logic [31:0]          shift_ff, shift_in;
   logic [15:0]          remain_ff, remain_in;
   logic [15:0]          limit_ff;
   logic [31:0]          shifted;
   logic [15:0]          remain_dec;

   assign shifted    = {shift_ff[23:0], item.data_byte};
   assign remain_dec = remain_ff - 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      remain_in = remain_ff;
      res_valid = 1'b0;
      result    = '{message_id: shift_ff[31:16], message_length: shift_ff[15:0],
                    payload_byte: 8'd0, has_byte: 1'b0, last: 1'b1,
                    status: STATUS_OK};
      if (phase_ff == PHASE_HEADER || phase_ff == PHASE_PAYLOAD) begin
         if (item.link_error) begin
            res_valid     = 1'b1;
            result.status = STATUS_LINK;
            phase_in      = PHASE_HALTED;
            if (phase_ff == PHASE_HEADER) begin
               result.message_id     = 16'd0;
               result.message_length = 16'd0;
            end
         end else if (phase_ff == PHASE_HEADER) begin
            shift_in = shifted;
            if (count_ff != HDR_CNT_W'(HEADER_BYTES - 1)) begin
               count_in = count_ff + HDR_CNT_W'(1);
            end else begin
               count_in              = '0;
               result.message_id     = shifted[31:16];
               result.message_length = shifted[15:0];
               if (shifted[31:16] > limit_ff) begin
                  res_valid     = 1'b1;
                  result.status = STATUS_ID_BIG;
                  phase_in      = PHASE_HALTED;
               end else if (shifted[15:0] > limit_ff) begin
                  res_valid     = 1'b1;
                  result.status = STATUS_LEN_BIG;
                  phase_in      = PHASE_HALTED;
               end else if (shifted[15:0] == 16'd0) begin
                  res_valid = 1'b1;
               end else begin
                  remain_in = shifted[15:0];
                  phase_in  = PHASE_PAYLOAD;
               end
            end
         end else begin
            res_valid           = 1'b1;
            remain_in           = remain_dec;
            result.payload_byte = item.data_byte;
            result.has_byte     = 1'b1;
            result.last         = (remain_dec == 16'd0);
            if (remain_dec == 16'd0) begin
               phase_in = PHASE_HEADER;
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         count_ff  <= '0;
         shift_ff  <= '0;
         remain_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

endmodule

@@ design/lpmd_out_reg.sv @@
// ----------------------------------------------------------------------------
// lpmd_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module lpmd_out_reg
   import lpmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic       res_valid,
   input  result_type result,
   input  logic       rsp_tready,
   output logic       rsp_valid,
   output result_type rsp_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = res_valid;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

@@ design/length_prefixed_message_deframer.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream into messages with a 4-byte id/length header.
//
// The req channel carries one received byte per beat, or a link error flag.
// Each message is a big-endian 16-bit id, a big-endian 16-bit length, then
// the payload. Header beats give no result. Every payload byte leaves on the
// rsp channel with its id and length, tlast on the final one; a zero-length
// message gives one empty beat. An id or length above the limit register, or
// a link error, gives one error beat, after which all input is dropped until
// reset. The limit must be written via csr_wr_en/csr_wr_data only while idle;
// the block does not enforce this. Throughput is one byte per cycle while the
// receiver keeps up; a beat is held in the input register and decoded into the
// result register. The input register advances only when the result register
// is empty or being read, so a stalled receiver backs up into req_tready after
// at most two held beats; nothing is lost. Reset clears the parser to header
// phase, empties both registers and sets the limit to 2048.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer
   import lpmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] link_error
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] message_id, [31:16] message_length,
                                    // [39:32] payload_byte
   output logic [2:0]  rsp_tuser,   // [0] has_byte, [2:1] status
   output logic        rsp_tlast
);

   item_type   req_item, item;
   logic       item_valid, advance, res_valid;
   result_type result, rsp_result;

   assign req_item = '{data_byte: req_tdata, link_error: req_tuser};
   assign advance  = item_valid && (!rsp_tvalid || rsp_tready);

   lpmd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lpmd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .item        (item),
      .res_valid   (res_valid),
      .result      (result)
   );

   lpmd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .res_valid  (res_valid),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.payload_byte, rsp_result.message_length,
                       rsp_result.message_id};
   assign rsp_tuser = {rsp_result.status, rsp_result.has_byte};
   assign rsp_tlast = rsp_result.last;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for length_prefixed_message_deframer. Bytes go in on the
// req stream under random gaps and backpressure; every beat accepted is run
// through a cycle-free model of the parser, and each rsp beat is checked
// field by field against the oldest predicted result. The limit register is
// swept over its reset value, 65535, 0 and random values. Since any error
// halts the block until reset, the run ends with one randomly chosen fault
// followed by beats that must all be dropped.
// ----------------------------------------------------------------------------
module testbench;
   import lpmd_pkg::*;

   localparam int FAULT_LINK_HDR = 0;
   localparam int FAULT_LINK_PAY = 1;
   localparam int FAULT_ID_BIG   = 2;
   localparam int FAULT_LEN_BIG  = 3;

   typedef struct packed {
      logic [7:0] data;
      logic       link_err;
      logic       has_literal;
      result_type literal;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   logic rsp_hold = 1'b0;
   int   tx_idle_pct = 6;
   int   rx_idle_pct = 47;
   int   fail_count = 0;

   // parser model state
   logic [15:0]          lim = LIMIT_RESET;
   logic [PHASE_W-1:0]   prs_phase = PHASE_HEADER;
   logic [HDR_CNT_W-1:0] hdr_cnt = '0;
   logic [31:0]          hdr_shift = '0;
   logic [15:0]          pay_left = '0;

   result_type pending_results[$];

   dir_row_type directed_rows[22] = '{
      // id 1, length 0: one empty beat
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{16'h0001, 16'h0000, 8'h00, 1'b0, 1'b1, STATUS_OK}},
      // id at the reset limit, length 3
      '{8'h08, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h03, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{16'h0800, 16'h0003, 8'hFF, 1'b1, 1'b0, STATUS_OK}},
      '{8'h00, 1'b0, 1'b1, '{16'h0800, 16'h0003, 8'h00, 1'b1, 1'b0, STATUS_OK}},
      '{8'hA5, 1'b0, 1'b1, '{16'h0800, 16'h0003, 8'hA5, 1'b1, 1'b1, STATUS_OK}},
      // id 0, length 1
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
      '{8'h5A, 1'b0, 1'b0, '0},
      // id 0x07ff, length 2
      '{8'h07, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h02, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0}, '{8'h7F, 1'b0, 1'b0, '0}
   };

   length_prefixed_message_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #1 clock = ~clock;

   task automatic deframe_step(input logic [7:0] b, input logic lerr,
                               output bit got, output result_type r);
      logic [15:0] id;
      logic [15:0] len;
      got = 1'b0;
      r = '0;
      id = hdr_shift[31:16];
      len = hdr_shift[15:0];
      if (prs_phase == PHASE_HEADER || prs_phase == PHASE_PAYLOAD) begin
         if (lerr) begin
            got = 1'b1;
            r.last = 1'b1;
            r.status = STATUS_LINK;
            if (prs_phase == PHASE_PAYLOAD) begin
               r.message_id = id;
               r.message_length = len;
            end
            prs_phase = PHASE_HALTED;
         end else if (prs_phase == PHASE_HEADER) begin
            hdr_shift = {hdr_shift[23:0], b};
            if (hdr_cnt < HEADER_BYTES - 1) begin
               hdr_cnt = hdr_cnt + 1'b1;
            end else begin
               hdr_cnt = '0;
               id = hdr_shift[31:16];
               len = hdr_shift[15:0];
               got = 1'b1;
               r.message_id = id;
               r.message_length = len;
               r.last = 1'b1;
               if (id > lim) begin
                  r.status = STATUS_ID_BIG;
                  prs_phase = PHASE_HALTED;
               end else if (len > lim) begin
                  r.status = STATUS_LEN_BIG;
                  prs_phase = PHASE_HALTED;
               end else if (len != 16'd0) begin
                  got = 1'b0;
                  pay_left = len;
                  prs_phase = PHASE_PAYLOAD;
               end
            end
         end else begin
            pay_left = pay_left - 16'd1;
            got = 1'b1;
            r.message_id = id;
            r.message_length = len;
            r.payload_byte = b;
            r.has_byte = 1'b1;
            r.status = STATUS_OK;
            if (pay_left == 16'd0) begin
               r.last = 1'b1;
               prs_phase = PHASE_HEADER;
               hdr_cnt = '0;
            end
         end
      end
   endtask

   task automatic send_beat(input logic [7:0] d, input logic u);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= u;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic feed_byte(input logic [7:0] d, input logic u);
      bit got;
      result_type r;
      send_beat(d, u);
      deframe_step(d, u, got, r);
      if (got) pending_results.push_back(r);
   endtask

   task automatic send_message(input logic [15:0] id, input logic [15:0] len);
      feed_byte(id[15:8], 1'b0);
      feed_byte(id[7:0], 1'b0);
      feed_byte(len[15:8], 1'b0);
      feed_byte(len[7:0], 1'b0);
      for (int i = 0; i < len; i++) feed_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic send_random_messages(input int beats);
      int sent;
      int cap;
      logic [15:0] id;
      logic [15:0] len;
      sent = 0;
      while (sent < beats) begin
         cap = (lim < 24) ? int'(lim) : 24;
         if ($urandom_range(0, 19) == 0 && lim >= 200) cap = 200;
         case ($urandom_range(0, 9))
            0: id = lim;
            1: id = 16'd0;
            default: id = 16'($urandom_range(0, lim));
         endcase
         case ($urandom_range(0, 9))
            0: len = 16'd0;
            1: len = 16'(cap);
            default: len = 16'($urandom_range(0, cap));
         endcase
         send_message(id, len);
         sent += 4 + len;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lim = v;
   endtask

   // any error halts the parser for good, so exactly one fault ends the run
   task automatic send_fault_and_junk();
      int kind;
      int n;
      logic [15:0] id;
      logic [15:0] len;
      kind = $urandom_range(0, 3);
      case (kind)
         FAULT_LINK_HDR: begin
            n = $urandom_range(0, HEADER_BYTES - 1);
            for (int i = 0; i < n; i++) feed_byte(8'($urandom_range(0, 255)), 1'b0);
            feed_byte(8'($urandom_range(0, 255)), 1'b1);
         end
         FAULT_LINK_PAY: begin
            id = 16'($urandom_range(0, lim));
            len = 16'($urandom_range(2, 24));
            feed_byte(id[15:8], 1'b0);
            feed_byte(id[7:0], 1'b0);
            feed_byte(len[15:8], 1'b0);
            feed_byte(len[7:0], 1'b0);
            n = $urandom_range(0, len - 1);
            for (int i = 0; i < n; i++) feed_byte(8'($urandom_range(0, 255)), 1'b0);
            feed_byte(8'($urandom_range(0, 255)), 1'b1);
         end
         FAULT_ID_BIG: begin
            id = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(lim + 1, 65535));
            len = 16'($urandom_range(0, 65535));
            feed_byte(id[15:8], 1'b0);
            feed_byte(id[7:0], 1'b0);
            feed_byte(len[15:8], 1'b0);
            feed_byte(len[7:0], 1'b0);
         end
         default: begin
            id = 16'($urandom_range(0, lim));
            len = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(lim + 1, 65535));
            feed_byte(id[15:8], 1'b0);
            feed_byte(id[7:0], 1'b0);
            feed_byte(len[15:8], 1'b0);
            feed_byte(len[7:0], 1'b0);
         end
      endcase
      for (int i = 0; i < 30; i++)
         feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic check_beat(input result_type act);
      result_type exp_r;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected beat id=%h len=%h byte=%h has=%b last=%b st=%0d",
                  $time, act.message_id, act.message_length, act.payload_byte,
                  act.has_byte, act.last, act.status);
         fail_count++;
      end else begin
         exp_r = pending_results.pop_front();
         if (act.message_id !== exp_r.message_id ||
             act.message_length !== exp_r.message_length ||
             act.payload_byte !== exp_r.payload_byte ||
             act.has_byte !== exp_r.has_byte || act.last !== exp_r.last ||
             act.status !== exp_r.status) begin
            $display("%0t: exp id=%h len=%h byte=%h has=%b last=%b st=%0d", $time,
                     exp_r.message_id, exp_r.message_length, exp_r.payload_byte,
                     exp_r.has_byte, exp_r.last, exp_r.status);
            $display("%0t: got id=%h len=%h byte=%h has=%b last=%b st=%0d", $time,
                     act.message_id, act.message_length, act.payload_byte,
                     act.has_byte, act.last, act.status);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_beat('{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[39:32],
                      rsp_tuser[0], rsp_tlast, rsp_tuser[2:1]});
      rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= rx_idle_pct);
   end

   initial begin
      bit got;
      result_type r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(directed_rows); i++) begin
         send_beat(directed_rows[i].data, directed_rows[i].link_err);
         deframe_step(directed_rows[i].data, directed_rows[i].link_err, got, r);
         if (directed_rows[i].has_literal) pending_results.push_back(directed_rows[i].literal);
         else if (got) pending_results.push_back(r);
      end
      wait_drained();

      write_limit(16'hFFFF);
      send_random_messages(350);
      wait_drained();

      write_limit(16'h0000);
      send_random_messages(40);
      wait_drained();

      tx_idle_pct = 47;
      rx_idle_pct = 6;
      write_limit(16'($urandom_range(8, 4096)));
      send_random_messages(350);

      // long receiver stall while the sender keeps pushing
      fork
         send_random_messages(150);
         begin
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join
      wait_drained();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_limit(16'($urandom_range(16, 4096)));
      send_random_messages(350);
      send_fault_and_junk();
      wait_drained();
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("length_prefixed_message_deframer: match");
      end else begin
         $display("length_prefixed_message_deframer: mismatch");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("length_prefixed_message_deframer: mismatch");
      $finish;
   end

endmodule
